// ===== sv/assert_macros.svh =====
// Assertion macros used by the checker.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define SPL_ASSERT_IMP(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("same-cycle check failed");

// Next-cycle implication, disabled while reset is asserted.
`define SPL_ASSERT_NXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("next-cycle check failed");

`endif

// ===== sv/spl_pkg.sv =====
package spl_pkg;

	// Soft-knee table geometry.
	localparam int CLIP_TABLE_ENTRIES = 1024;
	localparam int SPAN_SHIFT = 13;
	localparam int IDX_W = $clog2(CLIP_TABLE_ENTRIES + 1);
	localparam int POS_W = SPAN_SHIFT + IDX_W;

	localparam int KNEE_Q15 = 31130;
	localparam int KNEE_WIDTH_Q15 = 1638;
	localparam logic [63:0] ONE_Q30 = 64'd1073741824;
	localparam logic [63:0] EXP_M1_Q30 = 64'd395007542;

	localparam int MUL_W = 25;
	localparam logic [24:0] ONE_Q24 = 25'd16777216;
	localparam logic [15:0] OUT_MAX = 16'd32767;
	localparam logic [15:0] THRESHOLD_RESET = 16'd58982;
	localparam logic [23:0] RELEASE_COEF_RESET = 24'd16772461;

	// The gain divider produces one quotient bit per step.
	localparam int DIV_STEPS = 24;
	localparam int CNT_W = $clog2(DIV_STEPS);

	localparam int CFG_INDEX_W = 1;
	localparam int CFG_DATA_W = 24;

	typedef enum logic [CFG_INDEX_W-1:0] {
		REG_THRESHOLD    = 1'b0,
		REG_RELEASE_COEF = 1'b1
	} spl_reg_t;

	typedef struct packed {
		logic signed [23:0] left_in;
		logic signed [23:0] right_in;
	} spl_in_t;

	typedef struct packed {
		logic signed [15:0] left_out;
		logic signed [15:0] right_out;
	} spl_out_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_DIV,
		ST_ENV_MUL,
		ST_ENV_ADD,
		ST_SCALE,
		ST_KNEE,
		ST_ROM_LO,
		ST_ROM_HI,
		ST_INTERP,
		ST_SUM,
		ST_STORE,
		ST_DONE
	} spl_state_t;

	typedef logic [15:0] clip_table_t [0:CLIP_TABLE_ENTRIES];

	// Bitwise long division, used only while the table is elaborated.
	function automatic logic [63:0] udiv64(input logic [63:0] num, input logic [63:0] dvs);
		logic [63:0] q;
		logic [63:0] rem;
		q = '0;
		rem = '0;
		for (int b = 63; b >= 0; b--) begin
			rem = {rem[62:0], num[b]};
			if (rem >= dvs) begin
				rem = rem - dvs;
				q[b] = 1'b1;
			end
		end
		return q;
	endfunction

	// e^(-z) in Q30 for z in Q30: series on the fraction, then one factor
	// of e^(-1) for each whole unit.
	function automatic logic [63:0] exp_neg_q30(input logic [63:0] z);
		logic [63:0] whole;
		logic [63:0] frac;
		logic [63:0] term;
		logic [63:0] r;
		logic signed [63:0] acc;
		whole = z >> 30;
		frac = z & (ONE_Q30 - 64'd1);
		acc = $signed(ONE_Q30);
		term = ONE_Q30;
		for (int k = 1; k <= 16; k++) begin
			term = udiv64((term * frac) >> 30, 64'(k));
			if (k[0])
				acc = acc - $signed(term);
			else
				acc = acc + $signed(term);
		end
		r = (acc > 0) ? 64'(acc) : 64'd0;
		while (whole != 64'd0 && r != 64'd0) begin
			r = (r * EXP_M1_Q30 + (64'd1 << 29)) >> 30;
			whole = whole - 64'd1;
		end
		return r;
	endfunction

	// Entry i is the knee plus the rounded knee width times tanh of the
	// table position, so the curve saturates toward 1.0.
	function automatic clip_table_t build_clip_table();
		clip_table_t tbl;
		logic [63:0] z;
		logic [63:0] e;
		logic [63:0] num;
		logic [63:0] den;
		logic [63:0] t;
		for (int i = 0; i <= CLIP_TABLE_ENTRIES; i++) begin
			z = udiv64(64'(i) << (SPAN_SHIFT + 31),
				64'(CLIP_TABLE_ENTRIES) * 64'(KNEE_WIDTH_Q15));
			e = exp_neg_q30(z);
			num = 64'(KNEE_WIDTH_Q15) * (ONE_Q30 - e);
			den = ONE_Q30 + e;
			t = udiv64(64'd2 * num + den, 64'd2 * den);
			tbl[i] = 16'(64'(KNEE_Q15) + t);
		end
		return tbl;
	endfunction

	localparam clip_table_t CLIP_TABLE = build_clip_table();

endpackage

// ===== sv/stereo_peak_limiter_soft_clip_top.sv =====
// Stereo-linked peak limiter with a soft-knee saturator. One stereo frame of
// signed Q4.20 samples goes in, one frame of signed Q1.15 samples comes out,
// in order. Both channels share a single gain envelope driven by the larger
// magnitude of the pair: attack is instant, release is a one-pole filter set
// by release_coef. A frame is served by the shared 24-step restoring divider
// that forms threshold/level (used only when the level is above the
// threshold), by the single shared 25x25 multiplier that serves the release
// update and both channel scalings and the table interpolation, and by the
// single-ported soft-knee ROM that is read twice per clipped channel. The
// result sits in an output register, so a finished frame may wait for the
// consumer while the next frame is already being accepted and processed.
// Registers must be written through cfg_we/cfg_index/cfg_data only while the
// block is idle; the block itself does not enforce this. The threshold is
// unsigned Q0.16 and the release coefficient Q0.24.
module stereo_peak_limiter_soft_clip_top (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              in_valid,
	output logic                              in_ready,
	input  spl_pkg::spl_in_t                  in_data,
	output logic                              out_valid,
	input  logic                              out_ready,
	output spl_pkg::spl_out_t                 out_data,
	input  logic                              cfg_we,
	input  logic [spl_pkg::CFG_INDEX_W-1:0]   cfg_index,
	input  logic [spl_pkg::CFG_DATA_W-1:0]    cfg_data
);

	// Sequencer state and configuration.
	spl_pkg::spl_state_t state_q, state_next;
	logic [15:0] threshold_q;
	logic [23:0] coef_q;
	logic [24:0] env_q;
	logic [spl_pkg::CNT_W-1:0] cnt_q;
	logic ch_q;
	logic out_valid_q;

	// Per-frame working registers.
	logic [23:0] mag_l_q, mag_r_q;
	logic neg_l_q, neg_r_q;
	logic [23:0] level_q;
	logic [23:0] rem_q;
	logic [24:0] wanted_q;
	logic [2*spl_pkg::MUL_W-1:0] prod_q;
	logic [spl_pkg::IDX_W-1:0] idx_q;
	logic [spl_pkg::SPAN_SHIFT-1:0] fr_q;
	logic [15:0] rom_q, lo_q, kmag_q;
	logic [15:0] res_l_q, res_r_q;
	spl_pkg::spl_out_t out_q;

	// Combinational helpers.
	logic in_fire;
	logic out_load;
	logic [23:0] in_mag_l, in_mag_r, in_level;
	logic [19:0] thr_q420;
	logic level_over;
	logic [24:0] rem_shift;
	logic div_ge;
	logic div_last;
	logic env_attack;
	logic mul_en;
	logic [spl_pkg::MUL_W-1:0] mul_a, mul_b;
	logic [2*spl_pkg::MUL_W-1:0] env_round;
	logic [2*spl_pkg::MUL_W-1:0] m_round;
	logic [18:0] knee_m;
	logic knee_pass;
	logic [18:0] knee_d;
	logic knee_far;
	logic [spl_pkg::POS_W-1:0] knee_pos;
	logic [spl_pkg::IDX_W-1:0] rom_addr;
	logic [15:0] interp_diff;
	logic [2*spl_pkg::MUL_W-1:0] interp_round;
	logic [16:0] interp_sum;
	logic cur_neg;
	logic [15:0] signed_res;

	assign in_fire = in_valid && in_ready;
	assign out_load = (state_q == spl_pkg::ST_DONE) && (!out_valid_q || out_ready);

	// Magnitudes of the incoming pair. The most negative code maps to 2^23.
	assign in_mag_l = in_data.left_in[23] ? (~in_data.left_in + 24'd1) : in_data.left_in;
	assign in_mag_r = in_data.right_in[23] ? (~in_data.right_in + 24'd1) : in_data.right_in;
	assign in_level = (in_mag_l > in_mag_r) ? in_mag_l : in_mag_r;
	assign thr_q420 = {threshold_q, 4'b0000};
	assign level_over = in_level > {4'b0000, thr_q420};

	// One restoring-division step. The partial remainder always stays
	// below the level, so the quotient fits in 24 bits.
	assign rem_shift = {rem_q, 1'b0};
	assign div_ge = rem_shift >= {1'b0, level_q};
	assign div_last = cnt_q == spl_pkg::CNT_W'(spl_pkg::DIV_STEPS - 1);

	assign env_attack = wanted_q < env_q;

	// Release: env + round((1 - c) * (wanted - env)), which equals the
	// one-pole blend since wanted is at least env on this path.
	assign env_round = prod_q + (50'd1 << 23);

	// Channel scaling rounds the magnitude half up into Q1.15.
	assign m_round = prod_q + (50'd1 << 28);
	assign knee_m = m_round[47:29];
	assign knee_pass = knee_m <= 19'(spl_pkg::KNEE_Q15);
	assign knee_d = knee_m - 19'(spl_pkg::KNEE_Q15);
	assign knee_far = |knee_d[18:spl_pkg::SPAN_SHIFT];
	assign knee_pos = spl_pkg::POS_W'(knee_d[spl_pkg::SPAN_SHIFT-1:0]) *
		spl_pkg::POS_W'(spl_pkg::CLIP_TABLE_ENTRIES);

	// Table interpolation between the two neighboring entries.
	assign interp_diff = (rom_q >= lo_q) ? (rom_q - lo_q) : 16'd0;
	assign interp_round = prod_q + (50'd1 << (spl_pkg::SPAN_SHIFT - 1));
	assign interp_sum = {1'b0, lo_q} +
		{1'b0, interp_round[spl_pkg::SPAN_SHIFT+15:spl_pkg::SPAN_SHIFT]};

	assign cur_neg = ch_q ? neg_r_q : neg_l_q;
	assign signed_res = cur_neg ? (~kmag_q + 16'd1) : kmag_q;

	// Next-state logic.
	always_comb begin
		state_next = state_q;
		unique case (state_q)
			spl_pkg::ST_IDLE: begin
				if (in_fire)
					state_next = level_over ? spl_pkg::ST_DIV : spl_pkg::ST_ENV_MUL;
			end
			spl_pkg::ST_DIV: begin
				if (div_last)
					state_next = spl_pkg::ST_ENV_MUL;
			end
			spl_pkg::ST_ENV_MUL: begin
				state_next = env_attack ? spl_pkg::ST_SCALE : spl_pkg::ST_ENV_ADD;
			end
			spl_pkg::ST_ENV_ADD: begin
				state_next = spl_pkg::ST_SCALE;
			end
			spl_pkg::ST_SCALE: begin
				state_next = spl_pkg::ST_KNEE;
			end
			spl_pkg::ST_KNEE: begin
				state_next = knee_pass ? spl_pkg::ST_STORE : spl_pkg::ST_ROM_LO;
			end
			spl_pkg::ST_ROM_LO: begin
				state_next = spl_pkg::ST_ROM_HI;
			end
			spl_pkg::ST_ROM_HI: begin
				state_next = spl_pkg::ST_INTERP;
			end
			spl_pkg::ST_INTERP: begin
				state_next = spl_pkg::ST_SUM;
			end
			spl_pkg::ST_SUM: begin
				state_next = spl_pkg::ST_STORE;
			end
			spl_pkg::ST_STORE: begin
				state_next = ch_q ? spl_pkg::ST_DONE : spl_pkg::ST_SCALE;
			end
			spl_pkg::ST_DONE: begin
				if (out_load)
					state_next = spl_pkg::ST_IDLE;
			end
			default: begin
				state_next = spl_pkg::ST_IDLE;
			end
		endcase
	end

	// Sequencer outputs: handshake, multiplier operands and ROM address.
	always_comb begin
		in_ready = 1'b0;
		mul_en = 1'b0;
		mul_a = '0;
		mul_b = '0;
		rom_addr = idx_q;
		unique case (state_q)
			spl_pkg::ST_IDLE: begin
				in_ready = 1'b1;
			end
			spl_pkg::ST_ENV_MUL: begin
				mul_en = 1'b1;
				mul_a = spl_pkg::ONE_Q24 - {1'b0, coef_q};
				mul_b = wanted_q - env_q;
			end
			spl_pkg::ST_SCALE: begin
				mul_en = 1'b1;
				mul_a = {1'b0, ch_q ? mag_r_q : mag_l_q};
				mul_b = env_q;
			end
			spl_pkg::ST_ROM_HI: begin
				if (idx_q != spl_pkg::IDX_W'(spl_pkg::CLIP_TABLE_ENTRIES))
					rom_addr = idx_q + spl_pkg::IDX_W'(1);
			end
			spl_pkg::ST_INTERP: begin
				mul_en = 1'b1;
				mul_a = spl_pkg::MUL_W'(interp_diff);
				mul_b = spl_pkg::MUL_W'(fr_q);
			end
			default: begin
				in_ready = 1'b0;
			end
		endcase
	end

	// Control state, configuration and the gain envelope.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= spl_pkg::ST_IDLE;
			threshold_q <= spl_pkg::THRESHOLD_RESET;
			coef_q <= spl_pkg::RELEASE_COEF_RESET;
			env_q <= spl_pkg::ONE_Q24;
			cnt_q <= '0;
			ch_q <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_next;
			if (cfg_we) begin
				unique case (spl_pkg::spl_reg_t'(cfg_index))
					spl_pkg::REG_THRESHOLD:    threshold_q <= cfg_data[15:0];
					spl_pkg::REG_RELEASE_COEF: coef_q <= cfg_data;
				endcase
			end
			if (in_fire) begin
				cnt_q <= '0;
				ch_q <= 1'b0;
			end
			if (state_q == spl_pkg::ST_DIV)
				cnt_q <= cnt_q + spl_pkg::CNT_W'(1);
			if (state_q == spl_pkg::ST_ENV_MUL && env_attack)
				env_q <= wanted_q;
			if (state_q == spl_pkg::ST_ENV_ADD)
				env_q <= env_q + env_round[48:24];
			if (state_q == spl_pkg::ST_STORE)
				ch_q <= 1'b1;
			if (out_load)
				out_valid_q <= 1'b1;
			else if (out_ready)
				out_valid_q <= 1'b0;
		end
	end

	// Datapath registers.
	always_ff @(posedge clk) begin
		if (in_fire) begin
			mag_l_q <= in_mag_l;
			mag_r_q <= in_mag_r;
			neg_l_q <= in_data.left_in[23];
			neg_r_q <= in_data.right_in[23];
			level_q <= in_level;
			rem_q <= {4'b0000, thr_q420};
			wanted_q <= level_over ? 25'd0 : spl_pkg::ONE_Q24;
		end
		if (state_q == spl_pkg::ST_DIV) begin
			rem_q <= div_ge ? 24'(rem_shift - {1'b0, level_q}) : rem_shift[23:0];
			wanted_q <= {wanted_q[23:0], div_ge};
		end
		if (mul_en)
			prod_q <= (2*spl_pkg::MUL_W)'(mul_a) * (2*spl_pkg::MUL_W)'(mul_b);
		if (state_q == spl_pkg::ST_KNEE) begin
			kmag_q <= knee_m[15:0];
			if (knee_far) begin
				idx_q <= spl_pkg::IDX_W'(spl_pkg::CLIP_TABLE_ENTRIES);
				fr_q <= '0;
			end else begin
				idx_q <= knee_pos[spl_pkg::POS_W-1:spl_pkg::SPAN_SHIFT];
				fr_q <= knee_pos[spl_pkg::SPAN_SHIFT-1:0];
			end
		end
		rom_q <= spl_pkg::CLIP_TABLE[rom_addr];
		if (state_q == spl_pkg::ST_ROM_HI)
			lo_q <= rom_q;
		if (state_q == spl_pkg::ST_SUM)
			kmag_q <= (interp_sum > {1'b0, spl_pkg::OUT_MAX}) ? spl_pkg::OUT_MAX
				: interp_sum[15:0];
		if (state_q == spl_pkg::ST_STORE) begin
			if (ch_q)
				res_r_q <= signed_res;
			else
				res_l_q <= signed_res;
		end
		if (out_load) begin
			out_q.left_out <= res_l_q;
			out_q.right_out <= res_r_q;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data = out_q;

endmodule

// ===== sv/spl_checker.sv =====
`include "assert_macros.svh"

module spl_checker (
	input logic              clk,
	input logic              arst_n,
	input logic              in_valid,
	input logic              in_ready,
	input spl_pkg::spl_in_t  in_data,
	input logic              out_valid,
	input logic              out_ready,
	input spl_pkg::spl_out_t out_data
);

	logic in_fire;

	assign in_fire = in_valid && in_ready && (in_data.left_in == in_data.left_in);

	// A held result keeps its value until it is taken.
	`SPL_ASSERT_NXT(a_out_hold, clk, arst_n, out_valid && !out_ready, out_valid && $stable(out_data))

	// The block works on one frame at a time.
	`SPL_ASSERT_NXT(a_busy_after_accept, clk, arst_n, in_fire, !in_ready)

	// No result can appear in the cycle right after an accept.
	`SPL_ASSERT_NXT(a_no_bypass, clk, arst_n, in_fire, !$rose(out_valid))

	// The saturator never produces the most negative code.
	`SPL_ASSERT_IMP(a_out_range, clk, arst_n, out_valid, (out_data.left_out != 16'h8000) && (out_data.right_out != 16'h8000))

endmodule

bind stereo_peak_limiter_soft_clip_top spl_checker u_spl_checker (.*);

// ===== bench/tb_stereo_peak_limiter_soft_clip_top.sv =====
`timescale 1ns / 100ps

// Bench for the stereo-linked peak limiter. Frames go in through a valid/ready
// channel and every accepted frame is run through a local bit-exact model of
// the limiter right away. The predicted output frame is queued, and a checker
// compares each frame that leaves the block with the oldest prediction.
module tb_stereo_peak_limiter_soft_clip_top;

	typedef longint unsigned u64_t;

	// Limiter arithmetic, restated here in the bench's own terms.
	localparam int KNEE_POINTS = 1024;
	localparam int KNEE_SPAN_SHIFT = 13;
	localparam u64_t KNEE_LEVEL = 64'd31130;
	localparam u64_t KNEE_WIDTH = 64'd1638;
	localparam u64_t UNITY_Q24 = 64'd16777216;
	localparam u64_t UNITY_Q30 = 64'd1073741824;
	localparam u64_t INV_E_Q30 = 64'd395007542;
	localparam u64_t PEAK_Q15 = 64'd32767;
	localparam logic [15:0] DEFAULT_THRESHOLD = 16'd58982;
	localparam logic [23:0] DEFAULT_RELEASE = 24'd16772461;

	// The settle time covers the longest time that a frame spends inside the
	// block. The watchdog limit covers the long receiver hold-off several times.
	localparam int SETTLE_CYCLES = 45;
	localparam int RX_HOLD_CYCLES = 300;
	localparam int STALL_LIMIT = 2000;

	logic clk = 1'b0;
	logic arst_n;
	logic in_valid;
	logic in_ready;
	spl_pkg::spl_in_t in_data;
	logic out_valid;
	logic out_ready;
	spl_pkg::spl_out_t out_data;
	logic cfg_we;
	logic [spl_pkg::CFG_INDEX_W-1:0] cfg_index;
	logic [spl_pkg::CFG_DATA_W-1:0] cfg_data;

	// Local copy of the limiter state and its registers.
	logic [15:0] lim_threshold;
	logic [23:0] lim_release;
	logic [24:0] lim_envelope;
	u64_t knee_curve [0:KNEE_POINTS];

	spl_pkg::spl_out_t expected_frames [$];

	bit tx_idle_on;
	bit rx_idle_on;
	int rx_hold_len;
	int fail_count;
	int frames_sent;
	int frames_checked;
	int settings_used;
	int quiet_cycles;

	stereo_peak_limiter_soft_clip_top i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.in_data(in_data),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_data(out_data),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	always #5 clk = ~clk;

	// e^(-z) with z and the result in Q30. The fractional part is handled by a
	// 16-term series, and each whole unit multiplies in one more e^(-1).
	function automatic u64_t decay_q30(input u64_t z);
		u64_t whole;
		u64_t frac;
		u64_t term;
		u64_t r;
		longint acc;
		whole = z >> 30;
		frac = z & (UNITY_Q30 - 1);
		acc = UNITY_Q30;
		term = UNITY_Q30;
		for (int k = 1; k <= 16; k++) begin
			term = ((term * frac) >> 30) / u64_t'(k);
			if (k % 2 == 1) begin
				acc = acc - longint'(term);
			end else begin
				acc = acc + longint'(term);
			end
		end
		r = (acc > 0) ? u64_t'(acc) : 64'd0;
		while (whole != 0 && r != 0) begin
			r = (r * INV_E_Q30 + (u64_t'(1) << 29)) >> 30;
			whole = whole - 1;
		end
		return r;
	endfunction

	// The saturation curve above the knee: knee plus the rounded knee width
	// times tanh of the position, with tanh formed as (1 - e) / (1 + e).
	function automatic void build_knee_curve();
		u64_t z;
		u64_t e;
		u64_t num;
		u64_t den;
		for (int i = 0; i <= KNEE_POINTS; i++) begin
			z = (u64_t'(i) << (KNEE_SPAN_SHIFT + 31)) / (u64_t'(KNEE_POINTS) * KNEE_WIDTH);
			e = decay_q30(z);
			num = KNEE_WIDTH * (UNITY_Q30 - e);
			den = UNITY_Q30 + e;
			knee_curve[i] = KNEE_LEVEL + (2 * num + den) / (2 * den);
		end
	endfunction

	// Magnitude of a Q4.20 sample; the most negative code keeps its full 8.0.
	function automatic u64_t sample_mag(input logic [23:0] v);
		return v[23] ? (u64_t'(25'h1000000) - u64_t'(v)) : u64_t'(v);
	endfunction

	// Soft knee on a Q1.15 magnitude, interpolating between curve points.
	function automatic u64_t shaped_mag(input u64_t m);
		u64_t r;
		u64_t d;
		u64_t pos;
		u64_t idx;
		u64_t fr;
		u64_t lo;
		u64_t hi;
		u64_t diff;
		if (m <= KNEE_LEVEL) begin
			r = m;
		end else begin
			d = m - KNEE_LEVEL;
			if (d >= (u64_t'(1) << KNEE_SPAN_SHIFT)) begin
				r = knee_curve[KNEE_POINTS];
			end else begin
				pos = d * KNEE_POINTS;
				idx = pos >> KNEE_SPAN_SHIFT;
				fr = pos & ((u64_t'(1) << KNEE_SPAN_SHIFT) - 1);
				lo = knee_curve[idx];
				hi = knee_curve[idx + 1];
				diff = (hi >= lo) ? hi - lo : 64'd0;
				r = lo + ((diff * fr + (u64_t'(1) << (KNEE_SPAN_SHIFT - 1))) >> KNEE_SPAN_SHIFT);
			end
		end
		return (r > PEAK_Q15) ? PEAK_Q15 : r;
	endfunction

	// Scales one channel by the envelope, rounding the magnitude half up, then
	// shapes it and puts the sign back. A negative zero comes out as 0.
	function automatic logic [15:0] scale_channel(input logic [23:0] raw, input u64_t env);
		u64_t m;
		u64_t s;
		m = (sample_mag(raw) * env + (u64_t'(1) << 28)) >> 29;
		s = shaped_mag(m);
		return raw[23] ? 16'(u64_t'(65536) - s) : 16'(s);
	endfunction

	// One frame through the limiter: linked level, wanted gain, instant attack
	// or one-pole release, then both channels scaled by the new envelope.
	function automatic spl_pkg::spl_out_t limit_frame(input spl_pkg::spl_in_t f);
		spl_pkg::spl_out_t o;
		u64_t lvl_l;
		u64_t lvl_r;
		u64_t level;
		u64_t thr;
		u64_t wanted;
		u64_t env;
		u64_t c;
		lvl_l = sample_mag(f.left_in);
		lvl_r = sample_mag(f.right_in);
		level = (lvl_l > lvl_r) ? lvl_l : lvl_r;
		thr = u64_t'(lim_threshold) << 4;
		wanted = (level > thr) ? (thr << 24) / level : UNITY_Q24;
		env = u64_t'(lim_envelope);
		if (wanted < env) begin
			env = wanted;
		end else begin
			c = u64_t'(lim_release);
			env = (c * env + (UNITY_Q24 - c) * wanted + (u64_t'(1) << 23)) >> 24;
		end
		if (env > UNITY_Q24) begin
			env = UNITY_Q24;
		end
		lim_envelope = 25'(env);
		o.left_out = scale_channel(f.left_in, env);
		o.right_out = scale_channel(f.right_in, env);
		return o;
	endfunction

	function automatic logic [23:0] signed_level(input int unsigned m);
		return $urandom_range(0, 1) ? 24'(-int'(m)) : 24'(m);
	endfunction

	function automatic logic [23:0] extreme_sample();
		case ($urandom_range(0, 4))
			0: begin
				return 24'h7FFFFF;
			end
			1: begin
				return 24'h800000;
			end
			2: begin
				return 24'h000000;
			end
			3: begin
				return 24'hFFFFFF;
			end
			default: begin
				return 24'h000001;
			end
		endcase
	endfunction

	// Random frame drawn from a mix of traffic: full-range noise, levels near
	// the threshold so attack and release both get work, quiet material,
	// moderate levels around full scale, extremes, and one silent channel.
	function automatic spl_pkg::spl_in_t random_frame();
		spl_pkg::spl_in_t f;
		int base;
		case ($urandom_range(0, 9))
			0, 1, 2: begin
				f.left_in = 24'($urandom);
				f.right_in = 24'($urandom);
			end
			3, 4: begin
				base = int'(lim_threshold) * 16 - 65536 + int'($urandom_range(0, 131072));
				if (base < 0) begin
					base = 0;
				end
				f.left_in = signed_level(base);
				f.right_in = signed_level($urandom_range(0, base));
			end
			5, 6: begin
				f.left_in = signed_level($urandom_range(0, 4095));
				f.right_in = signed_level($urandom_range(0, 4095));
			end
			7: begin
				f.left_in = signed_level($urandom_range(0, 1 << 21));
				f.right_in = signed_level($urandom_range(0, 1 << 21));
			end
			8: begin
				f.left_in = extreme_sample();
				f.right_in = extreme_sample();
			end
			default: begin
				f.left_in = 24'h000000;
				f.right_in = signed_level($urandom_range(0, 1 << 22));
			end
		endcase
		if ($urandom_range(0, 1)) begin
			{f.left_in, f.right_in} = {f.right_in, f.left_in};
		end
		return f;
	endfunction

	// Offers one frame and returns at the edge where it is accepted. Valid is
	// only dropped when an idle gap is inserted, so a back-to-back frame keeps
	// valid high without a second assignment in the same time step.
	task automatic send_frame(input spl_pkg::spl_in_t f);
		int gap;
		gap = 0;
		if (tx_idle_on && $urandom_range(0, 3) == 0) begin
			gap = $urandom_range(1, 11);
		end
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		in_data <= f;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		expected_frames = {expected_frames, limit_frame(f)};
		frames_sent++;
	endtask

	task automatic send_pair(input logic [23:0] l, input logic [23:0] r);
		spl_pkg::spl_in_t f;
		f.left_in = l;
		f.right_in = r;
		send_frame(f);
	endtask

	// Stops offering frames and waits until every predicted frame has come
	// back, then lets the block settle so that it is idle afterwards.
	task automatic wait_idle();
		in_valid <= 1'b0;
		while (expected_frames.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// Writes both registers on consecutive edges; only called while idle.
	// The threshold write carries random upper bits, which the block drops.
	task automatic set_limits(input logic [15:0] thr, input logic [23:0] coef);
		cfg_we <= 1'b1;
		cfg_index <= spl_pkg::REG_THRESHOLD;
		cfg_data <= {8'($urandom), thr};
		@(posedge clk);
		cfg_index <= spl_pkg::REG_RELEASE_COEF;
		cfg_data <= coef;
		@(posedge clk);
		cfg_we <= 1'b0;
		lim_threshold = thr;
		lim_release = coef;
		settings_used++;
	endtask

	// Reset values: 0.90 threshold and the slow default release. Covers the
	// full-scale extremes, the most negative code, a level sitting exactly on
	// the threshold and one just above it.
	task automatic test_reset_defaults();
		settings_used++;
		send_pair(24'd0, 24'd0);
		send_pair(24'h7FFFFF, 24'h7FFFFF);
		send_pair(24'h800000, 24'h800000);
		send_pair(24'h7FFFFF, 24'h800000);
		send_pair(24'h800000, 24'd0);
		send_pair(24'd0, 24'h7FFFFF);
		send_pair(24'hFFFFFF, 24'h000001);
		send_pair(24'hFFFFFF, 24'hFFFFFF);
		send_pair(24'd500000, -24'd300000);
		send_pair(24'd943712, -24'd943712);
		send_pair(24'd943713, 24'd0);
		wait_idle();
	endtask

	// Zero threshold with an instant release: a silent frame restores unity
	// gain, any nonzero level mutes both channels.
	task automatic test_zero_threshold();
		set_limits(16'd0, 24'd0);
		send_pair(24'd0, 24'd0);
		send_pair(24'd1, 24'd0);
		send_pair(-24'd1048576, 24'd1048575);
		send_pair(24'd0, 24'd0);
		send_pair(-24'd16, -24'd16);
		wait_idle();
	endtask

	// Threshold at its top and the slowest release. Frames land on the knee,
	// just above it and near full scale, and small negative samples either
	// round to zero or to minus one.
	task automatic test_knee_region();
		set_limits(16'hFFFF, 24'hFFFFFF);
		send_pair(24'd996160, -24'd996160);
		send_pair(24'd996192, -24'd996224);
		send_pair(-24'd8, -24'd16);
		send_pair(24'd1048560, -24'd1048560);
		send_pair(24'd1030000, 24'd1020000);
		send_pair(24'd1048575, 24'd0);
		send_pair(-24'd1040000, 24'd15);
		send_pair(24'd0, 24'd0);
		wait_idle();
	endtask

	// Random traffic over several register settings, the extremes included.
	// Idling on both sides is switched on and off in stretches.
	task automatic test_random_settings();
		logic [15:0] thr;
		logic [23:0] coef;
		for (int ph = 0; ph < 6; ph++) begin
			case (ph)
				0: begin
					thr = 16'hFFFF;
					coef = 24'($urandom_range(16000000, 16777215));
				end
				1: begin
					thr = 16'd0;
					coef = 24'($urandom);
				end
				2: begin
					thr = 16'($urandom);
					coef = 24'd0;
				end
				3: begin
					thr = 16'($urandom);
					coef = 24'hFFFFFF;
				end
				4: begin
					thr = 16'($urandom);
					coef = 24'($urandom);
				end
				default: begin
					thr = 16'($urandom_range(50000, 65535));
					coef = 24'($urandom_range(15000000, 16777000));
				end
			endcase
			set_limits(thr, coef);
			for (int n = 0; n < 70; n++) begin
				if (n % 20 == 0) begin
					tx_idle_on = ($urandom_range(0, 2) != 0);
					rx_idle_on = ($urandom_range(0, 2) != 0);
				end
				send_frame(random_frame());
			end
			wait_idle();
		end
	endtask

	// The receiver holds off for a long stretch while frames keep coming, so
	// the output register fills, the next frame waits behind it, and input stalls.
	task automatic test_output_backpressure();
		tx_idle_on = 1'b0;
		rx_hold_len = RX_HOLD_CYCLES;
		for (int n = 0; n < 8; n++) begin
			send_frame(random_frame());
		end
		wait_idle();
	endtask

	// The sender pauses mid-stream until every result is back, with the
	// envelope state carried across the pause.
	task automatic test_sender_pause();
		tx_idle_on = 1'b1;
		rx_idle_on = 1'b1;
		for (int n = 0; n < 10; n++) begin
			send_frame(random_frame());
		end
		in_valid <= 1'b0;
		while (expected_frames.size() != 0) @(posedge clk);
		for (int n = 0; n < 10; n++) begin
			send_frame(random_frame());
		end
		wait_idle();
	endtask

	// Closing stretch with no idling on either side.
	task automatic test_gapless_stream();
		set_limits(16'($urandom_range(30000, 65535)), 24'($urandom_range(12000000, 16777215)));
		tx_idle_on = 1'b0;
		rx_idle_on = 1'b0;
		for (int n = 0; n < 80; n++) begin
			send_frame(random_frame());
		end
		wait_idle();
	endtask

	// Receiver side: ready is high except in random idle bursts or during a
	// requested hold-off, which is counted here.
	initial begin
		out_ready = 1'b0;
		@(posedge arst_n);
		forever begin
			if (rx_hold_len > 0) begin
				out_ready <= 1'b0;
				repeat (rx_hold_len) @(posedge clk);
				rx_hold_len = 0;
			end else if (rx_idle_on && $urandom_range(0, 4) == 0) begin
				out_ready <= 1'b0;
				repeat ($urandom_range(1, 11)) @(posedge clk);
			end else begin
				out_ready <= 1'b1;
				@(posedge clk);
			end
		end
	end

	// Every frame that leaves the block is compared with the oldest prediction.
	always @(posedge clk) begin
		spl_pkg::spl_out_t want;
		if (arst_n && out_valid && out_ready) begin
			if (expected_frames.size() == 0) begin
				$error("output item with nothing expected: left_out %0d, right_out %0d",
					out_data.left_out, out_data.right_out);
				fail_count++;
			end else begin
				want = expected_frames.pop_front();
				frames_checked++;
				if (out_data.left_out !== want.left_out) begin
					$error("left_out: expected %0d, got %0d", want.left_out, out_data.left_out);
					fail_count++;
				end
				if (out_data.right_out !== want.right_out) begin
					$error("right_out: expected %0d, got %0d", want.right_out,
						out_data.right_out);
					fail_count++;
				end
			end
		end
	end

	// Ends the run if neither channel moves an item for too long.
	always @(posedge clk) begin
		if (!arst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
			quiet_cycles <= 0;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
			if (quiet_cycles >= STALL_LIMIT) begin
				$display("Watchdog: no item moved for %0d cycles, %0d results outstanding",
					STALL_LIMIT, expected_frames.size());
				$display("Test completed with failures");
				$finish;
			end
		end
	end

	initial begin
		arst_n = 1'b0;
		in_valid = 1'b0;
		in_data = '0;
		cfg_we = 1'b0;
		cfg_index = spl_pkg::REG_THRESHOLD;
		cfg_data = '0;
		tx_idle_on = 1'b1;
		rx_idle_on = 1'b1;
		rx_hold_len = 0;
		fail_count = 0;
		frames_sent = 0;
		frames_checked = 0;
		settings_used = 0;
		lim_threshold = DEFAULT_THRESHOLD;
		lim_release = DEFAULT_RELEASE;
		lim_envelope = 25'(UNITY_Q24);
		build_knee_curve();
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_reset_defaults();
		test_zero_threshold();
		test_knee_region();
		test_random_settings();
		test_output_backpressure();
		test_sender_pause();
		test_gapless_stream();

		if (expected_frames.size() != 0) begin
			$error("%0d expected output items never arrived", expected_frames.size());
			fail_count++;
		end
		$display("Sent %0d frames and checked %0d across %0d register settings.",
			frames_sent, frames_checked, settings_used);
		$display("Included extremes, knee and zero-threshold cases, a long output stall ",
			"and a gapless closing stream.");
		if (fail_count == 0) begin
			$display("Test completed successfully");
		end else begin
			$display("Test completed with failures");
		end
		$finish;
	end

endmodule

// ===== sim.f =====
+incdir+sv
sv/spl_pkg.sv
sv/stereo_peak_limiter_soft_clip_top.sv
sv/spl_checker.sv
bench/tb_stereo_peak_limiter_soft_clip_top.sv
